// ===== hdl/blm_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers for the line minimizer.
package blm_pkg;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] GOLD_Q64 = 64'h61C8_8646_80B5_83EB;
    localparam logic [63:0] RECIP10 = 64'hCCCC_CCCC_CCCC_CCCD;
    localparam logic [62:0] TOL_RESET = 63'd4294967;
    localparam logic [32:0] CE_RESET = 33'd1;

    localparam logic [1:0] CFG_LOW = 2'd0;
    localparam logic [1:0] CFG_HIGH = 2'd1;
    localparam logic [1:0] CFG_TOL = 2'd2;
    localparam logic [1:0] CFG_CE = 2'd3;

    localparam logic OP_START = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_TRIAL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_REQ = 2'd0,
        KIND_MIN = 2'd1,
        KIND_IGN = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_S0, ST_S1,
        ST_U0, ST_U1, ST_U2, ST_U3,
        ST_IT0, ST_IT1, ST_IT2, ST_IT3, ST_IT4, ST_IT5, ST_IT6, ST_IT7,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
        ST_P10, ST_P11, ST_P12,
        ST_R0, ST_R1, ST_R2, ST_R3,
        ST_G0, ST_G1,
        ST_T0, ST_T1, ST_T2
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic done;
        logic over;
    } md_rsp_t;

    function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic sub);
        logic signed [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_abs(input logic signed [63:0] a);
        if (a == S64_MIN) begin
            return S64_MAX;
        end
        return a[63] ? -a : a;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? 64'(64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
        if (neg) begin
            return m[63] ? S64_MIN : $signed(64'(64'd0 - m));
        end
        return m[63] ? S64_MAX : $signed(m);
    endfunction

    function automatic logic signed [63:0] half_trunc(input logic signed [63:0] d);
        return (d >>> 1) + $signed({63'd0, d[63] & d[0]});
    endfunction

    function automatic logic signed [63:0] midpoint(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        return s[64:1];
    endfunction

endpackage

// ===== hdl/blm_muldiv.sv =====
// Shared shift-add multiplier and restoring divider.
module blm_muldiv
    import blm_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  md_req_t       req,
    input  logic [63:0]   op_a,
    input  logic [63:0]   op_b,
    output md_rsp_t       rsp,
    output logic [127:0]  prod,
    output logic [63:0]   quo
);

    localparam int MUL_STEPS = 64;
    localparam int DIV_STEPS = 128;

    logic          busy_reg, busy_next;
    logic          div_reg, div_next;
    logic          done_reg, done_next;
    logic          over_reg, over_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [63:0]   a_reg, a_next;
    logic [127:0]  p_reg, p_next;
    logic [63:0]   rem_reg, rem_next;
    logic [63:0]   q_reg, q_next;

    logic [64:0]   msum;
    logic [64:0]   rs;
    logic          qbit;

    always_comb begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        over_next = over_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        msum = {1'b0, p_reg[127:64]} + (p_reg[0] ? {1'b0, a_reg} : 65'd0);
        rs   = {rem_reg, p_reg[127]};
        qbit = (rs >= {1'b0, a_reg});
        if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            over_next = 1'b0;
            rem_next  = '0;
            q_next    = '0;
            if (req.is_div) begin
                a_next   = op_b;
                p_next   = {64'd0, op_a} << FRAC_BITS;
                cnt_next = 7'(DIV_STEPS - 1);
            end else begin
                a_next   = op_a;
                p_next   = {64'd0, op_b};
                cnt_next = 7'(MUL_STEPS - 1);
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                p_next   = {p_reg[126:0], 1'b0};
                rem_next = qbit ? 64'(rs - {1'b0, a_reg}) : rs[63:0];
                if (cnt_reg[6]) begin
                    over_next = over_reg | qbit;
                end else begin
                    q_next = {q_reg[62:0], qbit};
                end
            end else begin
                p_next = {msum, p_reg[63:1]};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg  <= div_next;
        over_reg <= over_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.over = over_reg;
    assign prod     = p_reg;
    assign quo      = q_reg;

endmodule

// ===== hdl/brent_line_minimizer.sv =====
// Top level: Brent line minimization sequencer around a shared ALU and mul/div unit.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  s_ (in)   | s_valid / s_ready  | s_op, s_f_value
//  m_ (out)  | m_valid / m_ready  | m_kind, m_point, m_bracket_low/high,
//            |                    | m_iteration_count
//  cfg       | cfg_wr_en          | cfg_addr, cfg_wr_data
//
// A start request and each function value run their arithmetic through the shared
// multiplier and divider. A function value leads to a golden-section step, or to a
// parabolic step that may fall back to golden section.
// aresetn is synchronous; there is no clearing pass. s_ready is low while a
// request is in work or a result waits in the output register.
module brent_line_minimizer
    import blm_pkg::*;
#(
    parameter int FRAC_BITS = 32,
    parameter int ITER_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [63:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [63:0] s_f_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [63:0] m_point,
    output logic signed [63:0] m_bracket_low,
    output logic signed [63:0] m_bracket_high,
    output logic [15:0]        m_iteration_count
);

    logic signed [63:0] ilow_reg, ihigh_reg;
    logic [62:0]        tol_cfg_reg;
    logic [32:0]        ce_reg;

    state_t st_reg, st_next;
    phase_t ph_reg, ph_next;

    logic signed [63:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [63:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [63:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [63:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [63:0] ls_reg, ls_next, ps_reg, ps_next;
    logic signed [63:0] trial_reg, trial_next;
    logic signed [63:0] fv_reg, fv_next;
    logic signed [63:0] g_reg, g_next, half_reg, half_next, mid_reg, mid_next;
    logic signed [63:0] tol_reg, tol_next, ttol_reg, ttol_next;
    logic signed [63:0] acc_reg, acc_next, d_reg, d_next, den_reg, den_next;
    logic signed [63:0] dwx_reg, dwx_next, a1_reg, a1_next;
    logic signed [63:0] b1_reg, b1_next, a2_reg, a2_next;
    logic               fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic               mneg_reg, mneg_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;

    logic               m_valid_reg;
    kind_t              m_kind_reg;
    logic signed [63:0] m_point_reg, m_lo_reg, m_hi_reg;
    logic [15:0]        m_iter_reg;

    logic               emit_en;
    kind_t              emit_kind;
    logic signed [63:0] emit_point;

    logic signed [63:0] alu_a, alu_b, alu_res, alu_abs;
    logic               alu_sub;

    md_req_t            md_req;
    md_rsp_t            md_rsp;
    logic [63:0]        md_a, md_b, md_quo;
    logic [127:0]       md_prod, prod_sh;
    logic               qm_over;
    logic signed [63:0] qmul_res, gmul_res, qdiv_res, tol10;
    logic signed [63:0] tol_s, ce_s;
    logic [31:0]        iter_ext;
    logic               s_fire;

    blm_muldiv #(
        .FRAC_BITS(FRAC_BITS)
    ) u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (md_req),
        .op_a   (md_a),
        .op_b   (md_b),
        .rsp    (md_rsp),
        .prod   (md_prod),
        .quo    (md_quo)
    );

    assign tol_s    = $signed({1'b0, tol_cfg_reg});
    assign ce_s     = $signed({31'd0, ce_reg});
    assign prod_sh  = md_prod >> FRAC_BITS;
    assign qm_over  = |(md_prod >> (FRAC_BITS + 64));
    assign qmul_res = from_mag(mneg_reg, qm_over ? '1 : prod_sh[63:0]);
    assign gmul_res = from_mag(mneg_reg, md_prod[127:64]);
    assign qdiv_res = from_mag(mneg_reg, md_rsp.over ? '1 : md_quo);
    assign tol10    = $signed({3'd0, md_prod[127:67]});
    assign alu_res  = sat_addsub(alu_a, alu_b, alu_sub);
    assign alu_abs  = sat_abs(alu_res);
    assign iter_ext = 32'(iter_reg);
    assign s_ready  = (st_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        st_next = st_reg;     ph_next = ph_reg;
        lo_next = lo_reg;     hi_next = hi_reg;
        bx_next = bx_reg;     by_next = by_reg;
        sx_next = sx_reg;     sy_next = sy_reg;
        tx_next = tx_reg;     ty_next = ty_reg;
        ls_next = ls_reg;     ps_next = ps_reg;
        trial_next = trial_reg; fv_next = fv_reg;
        g_next = g_reg;       half_next = half_reg; mid_next = mid_reg;
        tol_next = tol_reg;   ttol_next = ttol_reg;
        acc_next = acc_reg;   d_next = d_reg;   den_next = den_reg;
        dwx_next = dwx_reg;   a1_next = a1_reg; b1_next = b1_reg; a2_next = a2_reg;
        fa_next = fa_reg;     fb_next = fb_reg; fc_next = fc_reg;
        mneg_next = mneg_reg; iter_next = iter_reg;
        alu_a = '0; alu_b = '0; alu_sub = 1'b0;
        md_req = '0; md_a = '0; md_b = '0;
        emit_en = 1'b0; emit_kind = KIND_REQ; emit_point = bx_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_op == OP_START) begin
                        lo_next = ilow_reg;
                        hi_next = ihigh_reg;
                        iter_next = '0;
                        ph_next = PH_FIRST;
                        st_next = ST_S0;
                    end else if (ph_reg == PH_FIRST) begin
                        bx_next = trial_reg; sx_next = trial_reg; tx_next = trial_reg;
                        by_next = s_f_value; sy_next = s_f_value; ty_next = s_f_value;
                        st_next = ST_IT0;
                    end else if (ph_reg == PH_TRIAL) begin
                        fv_next = s_f_value;
                        st_next = ST_U0;
                    end else begin
                        emit_en = 1'b1;
                        emit_kind = KIND_IGN;
                    end
                end
            end
            ST_S0: begin
                alu_a = hi_reg; alu_b = lo_reg; alu_sub = 1'b1;
                ls_next = alu_res; ps_next = alu_res;
                md_req.start = 1'b1; md_a = mag(alu_res); md_b = GOLD_Q64;
                mneg_next = alu_res[63];
                st_next = ST_S1;
            end
            ST_S1: begin
                if (md_rsp.done) begin
                    alu_a = lo_reg; alu_b = gmul_res;
                    trial_next = alu_res;
                    emit_en = 1'b1; emit_kind = KIND_REQ; emit_point = alu_res;
                    st_next = ST_IDLE;
                end
            end
            ST_U0: begin
                alu_a = sx_reg; alu_b = bx_reg; alu_sub = 1'b1;
                fa_next = alu_abs < ce_s;
                st_next = ST_U1;
            end
            ST_U1: begin
                alu_a = tx_reg; alu_b = bx_reg; alu_sub = 1'b1;
                fb_next = alu_abs < ce_s;
                st_next = ST_U2;
            end
            ST_U2: begin
                alu_a = tx_reg; alu_b = sx_reg; alu_sub = 1'b1;
                fc_next = alu_abs < ce_s;
                st_next = ST_U3;
            end
            ST_U3: begin
                if (fv_reg <= by_reg) begin
                    if (trial_reg >= bx_reg) lo_next = bx_reg;
                    else hi_next = bx_reg;
                    tx_next = sx_reg; ty_next = sy_reg;
                    sx_next = bx_reg; sy_next = by_reg;
                    bx_next = trial_reg; by_next = fv_reg;
                end else begin
                    if (trial_reg >= bx_reg) hi_next = trial_reg;
                    else lo_next = trial_reg;
                    if (fv_reg <= sy_reg || fa_reg) begin
                        tx_next = sx_reg; ty_next = sy_reg;
                        sx_next = trial_reg; sy_next = fv_reg;
                    end else if (fv_reg <= ty_reg || fb_reg || fc_reg) begin
                        tx_next = trial_reg; ty_next = fv_reg;
                    end
                end
                if (iter_reg != '1) iter_next = iter_reg + 1'b1;
                st_next = ST_IT0;
            end
            ST_IT0: begin
                alu_a = hi_reg; alu_b = lo_reg; alu_sub = 1'b1;
                if (alu_abs <= tol_s) begin
                    ph_next = PH_IDLE;
                    emit_en = 1'b1; emit_kind = KIND_MIN;
                    st_next = ST_IDLE;
                end else begin
                    g_next = ps_reg;
                    ps_next = ls_reg;
                    half_next = half_trunc(alu_res);
                    mid_next = midpoint(lo_reg, hi_reg);
                    md_req.start = 1'b1; md_a = sat_abs(bx_reg); md_b = {1'b0, tol_cfg_reg};
                    mneg_next = 1'b0;
                    st_next = ST_IT1;
                end
            end
            ST_IT1: begin
                if (md_rsp.done) begin
                    acc_next = qmul_res;
                    md_req.start = 1'b1; md_a = {1'b0, tol_cfg_reg}; md_b = RECIP10;
                    st_next = ST_IT2;
                end
            end
            ST_IT2: begin
                if (md_rsp.done) begin
                    alu_a = acc_reg; alu_b = tol10;
                    tol_next = alu_res;
                    st_next = ST_IT3;
                end
            end
            ST_IT3: begin
                alu_a = tol_reg; alu_b = tol_reg;
                ttol_next = alu_res;
                st_next = ST_IT4;
            end
            ST_IT4: begin
                alu_a = bx_reg; alu_b = mid_reg; alu_sub = 1'b1;
                d_next = alu_abs;
                st_next = ST_IT5;
            end
            ST_IT5: begin
                alu_a = d_reg; alu_b = half_reg;
                if (alu_res <= ttol_reg) begin
                    ph_next = PH_IDLE;
                    emit_en = 1'b1; emit_kind = KIND_MIN;
                    st_next = ST_IDLE;
                end else begin
                    st_next = ST_IT6;
                end
            end
            ST_IT6: begin
                alu_a = bx_reg; alu_b = sx_reg; alu_sub = 1'b1;
                fa_next = alu_abs < ce_s;
                st_next = ST_IT7;
            end
            ST_IT7: begin
                alu_a = sx_reg; alu_b = tx_reg; alu_sub = 1'b1;
                st_next = (fa_reg && alu_abs < ce_s) ? ST_G0 : ST_P0;
            end
            ST_P0: begin
                alu_a = sx_reg; alu_b = bx_reg; alu_sub = 1'b1;
                dwx_next = alu_res;
                st_next = ST_P1;
            end
            ST_P1: begin
                alu_a = sy_reg; alu_b = ty_reg; alu_sub = 1'b1;
                a1_next = alu_res;
                st_next = ST_P2;
            end
            ST_P2: begin
                alu_a = sx_reg; alu_b = tx_reg; alu_sub = 1'b1;
                b1_next = alu_res;
                st_next = ST_P3;
            end
            ST_P3: begin
                alu_a = sy_reg; alu_b = by_reg; alu_sub = 1'b1;
                a2_next = alu_res;
                st_next = ST_P4;
            end
            ST_P4: begin
                md_req.start = 1'b1; md_a = mag(dwx_reg); md_b = mag(a1_reg);
                mneg_next = dwx_reg[63] ^ a1_reg[63];
                st_next = ST_P5;
            end
            ST_P5: begin
                if (md_rsp.done) begin
                    acc_next = qmul_res;
                    md_req.start = 1'b1; md_a = mag(b1_reg); md_b = mag(a2_reg);
                    mneg_next = b1_reg[63] ^ a2_reg[63];
                    st_next = ST_P6;
                end
            end
            ST_P6: begin
                if (md_rsp.done) begin
                    alu_a = acc_reg; alu_b = qmul_res; alu_sub = 1'b1;
                    den_next = alu_res;
                    st_next = ST_P7;
                end
            end
            ST_P7: begin
                alu_a = den_reg; alu_b = den_reg;
                den_next = alu_res;
                if (alu_res == '0) begin
                    trial_next = '0;
                    st_next = ST_R0;
                end else begin
                    md_req.start = 1'b1; md_a = mag(dwx_reg); md_b = mag(dwx_reg);
                    mneg_next = 1'b0;
                    st_next = ST_P8;
                end
            end
            ST_P8: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1; md_a = mag(qmul_res); md_b = mag(a1_reg);
                    mneg_next = qmul_res[63] ^ a1_reg[63];
                    st_next = ST_P9;
                end
            end
            ST_P9: begin
                if (md_rsp.done) begin
                    acc_next = qmul_res;
                    md_req.start = 1'b1; md_a = mag(b1_reg); md_b = mag(b1_reg);
                    mneg_next = 1'b0;
                    st_next = ST_P10;
                end
            end
            ST_P10: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1; md_a = mag(qmul_res); md_b = mag(a2_reg);
                    mneg_next = qmul_res[63] ^ a2_reg[63];
                    st_next = ST_P11;
                end
            end
            ST_P11: begin
                if (md_rsp.done) begin
                    alu_a = acc_reg; alu_b = qmul_res; alu_sub = 1'b1;
                    md_req.start = 1'b1; md_req.is_div = 1'b1;
                    md_a = mag(alu_res); md_b = mag(den_reg);
                    mneg_next = alu_res[63] ^ den_reg[63];
                    st_next = ST_P12;
                end
            end
            ST_P12: begin
                if (md_rsp.done) begin
                    alu_a = sx_reg; alu_b = qdiv_res; alu_sub = 1'b1;
                    trial_next = alu_res;
                    st_next = ST_R0;
                end
            end
            ST_R0: begin
                alu_a = trial_reg; alu_b = bx_reg; alu_sub = 1'b1;
                if (lo_reg <= trial_reg && trial_reg <= hi_reg &&
                    alu_abs < half_trunc(g_reg)) begin
                    st_next = ST_R1;
                end else begin
                    st_next = ST_G0;
                end
            end
            ST_R1: begin
                alu_a = trial_reg; alu_b = lo_reg; alu_sub = 1'b1;
                fa_next = alu_res < ttol_reg;
                st_next = ST_R2;
            end
            ST_R2: begin
                alu_a = hi_reg; alu_b = trial_reg; alu_sub = 1'b1;
                st_next = (fa_reg || alu_res < ttol_reg) ? ST_R3 : ST_T0;
            end
            ST_R3: begin
                alu_a = bx_reg; alu_b = tol_reg; alu_sub = (bx_reg >= mid_reg);
                trial_next = alu_res;
                st_next = ST_T0;
            end
            ST_G0: begin
                alu_sub = 1'b1;
                if (bx_reg < mid_reg) begin
                    alu_a = hi_reg; alu_b = bx_reg;
                end else begin
                    alu_a = bx_reg; alu_b = lo_reg;
                end
                ps_next = alu_res;
                md_req.start = 1'b1; md_a = mag(alu_res); md_b = GOLD_Q64;
                mneg_next = alu_res[63];
                st_next = ST_G1;
            end
            ST_G1: begin
                if (md_rsp.done) begin
                    alu_a = bx_reg; alu_b = gmul_res; alu_sub = !(bx_reg < mid_reg);
                    trial_next = alu_res;
                    st_next = ST_T0;
                end
            end
            ST_T0: begin
                alu_a = trial_reg; alu_b = bx_reg; alu_sub = 1'b1;
                fa_next = !alu_res[63];
                st_next = (alu_abs < tol_reg) ? ST_T1 : ST_T2;
            end
            ST_T1: begin
                alu_a = bx_reg; alu_b = tol_s; alu_sub = !fa_reg;
                trial_next = alu_res;
                st_next = ST_T2;
            end
            ST_T2: begin
                alu_a = trial_reg; alu_b = bx_reg; alu_sub = 1'b1;
                ls_next = alu_abs;
                ph_next = PH_TRIAL;
                emit_en = 1'b1; emit_kind = KIND_REQ; emit_point = trial_reg;
                st_next = ST_IDLE;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ilow_reg    <= '0;
            ihigh_reg   <= 64'sd1 <<< FRAC_BITS;
            tol_cfg_reg <= TOL_RESET;
            ce_reg      <= CE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LOW:  ilow_reg    <= cfg_wr_data;
                CFG_HIGH: ihigh_reg   <= cfg_wr_data;
                CFG_TOL:  tol_cfg_reg <= cfg_wr_data[62:0];
                CFG_CE:   ce_reg      <= cfg_wr_data[32:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            ph_reg      <= PH_IDLE;
            lo_reg      <= '0;
            hi_reg      <= '0;
            bx_reg      <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            ph_reg   <= ph_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            bx_reg   <= bx_next;
            iter_reg <= iter_next;
            if (emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        by_reg <= by_next;   sx_reg <= sx_next;   sy_reg <= sy_next;
        tx_reg <= tx_next;   ty_reg <= ty_next;
        ls_reg <= ls_next;   ps_reg <= ps_next;
        trial_reg <= trial_next; fv_reg <= fv_next;
        g_reg <= g_next;     half_reg <= half_next; mid_reg <= mid_next;
        tol_reg <= tol_next; ttol_reg <= ttol_next;
        acc_reg <= acc_next; d_reg <= d_next;   den_reg <= den_next;
        dwx_reg <= dwx_next; a1_reg <= a1_next; b1_reg <= b1_next; a2_reg <= a2_next;
        fa_reg <= fa_next;   fb_reg <= fb_next; fc_reg <= fc_next;
        mneg_reg <= mneg_next;
        if (emit_en) begin
            m_kind_reg  <= emit_kind;
            m_point_reg <= emit_point;
            m_lo_reg    <= lo_reg;
            m_hi_reg    <= hi_reg;
            m_iter_reg  <= (iter_ext > 32'h0000_FFFF) ? 16'hFFFF : iter_ext[15:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = m_kind_reg;
    assign m_point           = m_point_reg;
    assign m_bracket_low     = m_lo_reg;
    assign m_bracket_high    = m_hi_reg;
    assign m_iteration_count = m_iter_reg;

endmodule
